@@ src/utf8_stream_decoder_core_macros.svh @@
// ============================================================================
// utf8_stream_decoder_core_macros
// assertion helpers shared by the decoder modules
// ============================================================================
`ifndef UTF8_STREAM_DECODER_CORE_MACROS_SVH
`define UTF8_STREAM_DECODER_CORE_MACROS_SVH

// condition must hold at every clock edge out of reset
`define UTF8SD_ASSERT(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define UTF8SD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/utf8sd_pkg.sv @@
// ============================================================================
// utf8sd_pkg
// types and constants of the utf-8 stream decoder
// ============================================================================
package utf8sd_pkg;

   localparam int unsigned BYTE_WIDTH  = 8;
   localparam int unsigned CP_WIDTH    = 21;
   localparam int unsigned QUEUE_DEPTH = 4;

   localparam logic [CP_WIDTH-1:0] REPLACEMENT_CP = 21'd63;
   localparam logic [CP_WIDTH-1:0] SURROGATE_LO   = 21'h00D800;
   localparam logic [CP_WIDTH-1:0] SURROGATE_HI   = 21'h00DFFF;
   localparam logic [CP_WIDTH-1:0] CP_MAX         = 21'h10FFFF;
   localparam logic [CP_WIDTH-1:0] MIN_TWO        = 21'h000080;
   localparam logic [CP_WIDTH-1:0] MIN_THREE      = 21'h000800;
   localparam logic [CP_WIDTH-1:0] MIN_FOUR       = 21'h010000;

   typedef enum logic [2:0] {
      LEN_NONE  = 3'd0,
      LEN_TWO   = 3'd2,
      LEN_THREE = 3'd3,
      LEN_FOUR  = 3'd4
   } seq_len_type;

   typedef struct packed {
      logic [CP_WIDTH-1:0] char_value;
      logic                replaced;
      logic                run_last;
      logic                text_end;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

endpackage

@@ src/utf8sd_decode.sv @@
// ============================================================================
// utf8sd_decode
// sequence state and combinational decode of one byte into up to two results
// ============================================================================
`include "utf8_stream_decoder_core_macros.svh"

module utf8sd_decode import utf8sd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_accept,
   input  logic [BYTE_WIDTH-1:0] in_byte,
   input  logic                  in_final,
   output push_type              push
);

   seq_len_type         pend_len_ff, pend_len_in;
   logic [2:0]          taken_ff, taken_in;
   logic [CP_WIDTH-1:0] partial_ff, partial_in;
   logic                lead_ok_ff, lead_ok_in;

   logic                is_cont;
   logic [CP_WIDTH-1:0] shifted;
   logic [CP_WIDTH-1:0] min_value;
   logic                seq_bad;
   logic                do_lead;
   logic [1:0]          n;
   result_type          res [2];
   result_type          repl_res;

   assign is_cont  = (in_byte[7:6] == 2'b10);
   assign shifted  = {partial_ff[CP_WIDTH-7:0], in_byte[5:0]};
   assign repl_res = '{char_value: REPLACEMENT_CP, replaced: 1'b1,
                       run_last: 1'b0, text_end: 1'b0};

   always_comb begin
      unique case (pend_len_ff)
         LEN_TWO:   min_value = MIN_TWO;
         LEN_THREE: min_value = MIN_THREE;
         default:   min_value = MIN_FOUR;
      endcase
   end

   assign seq_bad = !lead_ok_ff || (shifted < min_value) ||
                    ((shifted >= SURROGATE_LO) && (shifted <= SURROGATE_HI)) ||
                    (shifted > CP_MAX);

   always_comb begin
      pend_len_in = pend_len_ff;
      taken_in    = taken_ff;
      partial_in  = partial_ff;
      lead_ok_in  = lead_ok_ff;
      res[0]      = '0;
      res[1]      = '0;
      n           = 2'd0;
      do_lead     = 1'b0;

      if (pend_len_ff != LEN_NONE) begin
         if (is_cont) begin
            partial_in = shifted;
            taken_in   = taken_ff + 3'd1;
            if (taken_in >= pend_len_ff) begin
               if (seq_bad) begin
                  res[0] = repl_res;
               end else begin
                  res[0] = '{char_value: shifted, replaced: 1'b0,
                             run_last: 1'b0, text_end: 1'b0};
               end
               n           = 2'd1;
               pend_len_in = LEN_NONE;
               taken_in    = 3'd0;
               partial_in  = '0;
               lead_ok_in  = 1'b1;
            end
         end else begin
            res[0]      = repl_res;
            n           = 2'd1;
            pend_len_in = LEN_NONE;
            taken_in    = 3'd0;
            partial_in  = '0;
            lead_ok_in  = 1'b1;
            do_lead     = 1'b1;
         end
      end else begin
         do_lead = 1'b1;
      end

      if (do_lead) begin
         priority if (!in_byte[7]) begin
            res[n[0]] = '{char_value: CP_WIDTH'(in_byte), replaced: 1'b0,
                          run_last: 1'b0, text_end: 1'b0};
            n = n + 2'd1;
         end else if (in_byte[7:5] == 3'b110) begin
            pend_len_in = LEN_TWO;
            taken_in    = 3'd1;
            partial_in  = CP_WIDTH'(in_byte[4:0]);
            lead_ok_in  = (in_byte >= 8'hC2);
         end else if (in_byte[7:4] == 4'b1110) begin
            pend_len_in = LEN_THREE;
            taken_in    = 3'd1;
            partial_in  = CP_WIDTH'(in_byte[3:0]);
            lead_ok_in  = 1'b1;
         end else if (in_byte[7:3] == 5'b11110) begin
            pend_len_in = LEN_FOUR;
            taken_in    = 3'd1;
            partial_in  = CP_WIDTH'(in_byte[2:0]);
            lead_ok_in  = (in_byte <= 8'hF4);
         end else begin
            res[n[0]] = repl_res;
            n = n + 2'd1;
         end
      end

      if (in_final) begin
         if (pend_len_in != LEN_NONE) begin
            res[n[0]] = repl_res;
            n = n + 2'd1;
         end
         pend_len_in = LEN_NONE;
         taken_in    = 3'd0;
         partial_in  = '0;
         lead_ok_in  = 1'b1;
      end

      if (n != 2'd0) begin
         res[n[1]].run_last = 1'b1;
         res[n[1]].text_end = in_final;
      end
   end

   assign push.count  = in_accept ? n : 2'd0;
   assign push.first  = res[0];
   assign push.second = res[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_len_ff <= LEN_NONE;
         taken_ff    <= 3'd0;
         partial_ff  <= '0;
         lead_ok_ff  <= 1'b1;
      end else if (in_accept) begin
         pend_len_ff <= pend_len_in;
         taken_ff    <= taken_in;
         partial_ff  <= partial_in;
         lead_ok_ff  <= lead_ok_in;
      end
   end

   // every last byte of a text yields a result and closes any open sequence
   `UTF8SD_ASSERT(a_final_has_result, !(in_accept && in_final) || (push.count != 2'd0), "final byte produced no result")
   `UTF8SD_ASSERT_NEXT(a_final_clears, in_accept && in_final, pend_len_ff == LEN_NONE, "sequence still open after end of text")
   // a pair of results always starts with the replacement of a cut sequence
   `UTF8SD_ASSERT(a_pair_first_repl, (push.count != 2'd2) || push.first.replaced, "two results without leading replacement")

endmodule

@@ src/utf8sd_queue.sv @@
// ============================================================================
// utf8sd_queue
// result queue taking up to two results per cycle and giving one per cycle
// ============================================================================
`include "utf8_stream_decoder_core_macros.svh"

module utf8sd_queue import utf8sd_pkg::*; #(
   parameter int unsigned Depth = QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  push_type   push,
   output logic       in_ready,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_data
);

   localparam int unsigned PtrW = $clog2(Depth);
   localparam int unsigned CntW = $clog2(Depth + 1);

   result_type      entries_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            pop;

   assign in_ready  = (count_ff <= CntW'(Depth - 2));
   assign out_valid = (count_ff != '0);
   assign pop       = out_valid && out_ready;
   assign out_data  = entries_ff[rd_ptr_ff];

   assign wr_ptr_in = wr_ptr_ff + PtrW'(push.count);
   assign rd_ptr_in = rd_ptr_ff + PtrW'(pop);
   assign count_in  = count_ff + CntW'(push.count) - CntW'(pop);

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entries_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entries_ff[wr_ptr_ff + PtrW'(1)] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `UTF8SD_ASSERT(a_no_overflow, count_ff <= CntW'(Depth), "result queue over capacity")
   `UTF8SD_ASSERT(a_push_has_room, (push.count == 2'd0) || in_ready, "results pushed without room for two")
   `UTF8SD_ASSERT_NEXT(a_pop_only_drains, pop && (push.count == 2'd0), count_ff == $past(count_ff) - CntW'(1), "queue level wrong after a lone pop")

endmodule

@@ src/utf8_stream_decoder_core.sv @@
// ============================================================================
// utf8_stream_decoder_core
// utf-8 byte stream to utf-32 code point decoder
// ============================================================================
// Takes one utf-8 byte per cycle and emits utf-32 code points; malformed,
// overlong, surrogate, out-of-range or cut-off sequences come out as '?'
// (63) with the replaced flag set. The byte is decoded in the cycle it is
// accepted and its results sit in a small result queue until the sink takes
// them in order. Sustained rate is one byte per cycle as long as the sink
// takes one result per cycle; a byte that both ends a broken sequence and
// yields another result puts two results into the queue. req_tready drops
// while the result queue has fewer than two free entries (QueueDepth, a power
// of two, at least two).
// ============================================================================
module utf8_stream_decoder_core import utf8sd_pkg::*; #(
   parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] byte_value
   input  logic        req_tlast,   // final_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [20:0] char_value, [23:21] zero
   output logic [1:0]  rsp_tuser,   // [0] replaced, [1] run_last
   output logic        rsp_tlast    // text_end
);

   push_type   push;
   result_type head;
   logic       in_accept;

   assign in_accept = req_tvalid && req_tready;

   utf8sd_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .in_accept (in_accept),
      .in_byte   (req_tdata),
      .in_final  (req_tlast),
      .push      (push)
   );

   utf8sd_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (head)
   );

   assign rsp_tdata = {3'b000, head.char_value};
   assign rsp_tuser = {head.run_last, head.replaced};
   assign rsp_tlast = head.text_end;

endmodule

@@ sim/utf8_stream_decoder_core_tb.sv @@
// ============================================================================
// utf8_stream_decoder_core_tb
// self-checking testbench for the utf-8 stream decoder core
// ============================================================================
// Feeds byte transactions into the decoder and predicts the code point
// transactions that each accepted byte must produce. Every result transaction
// is checked field by field against the oldest prediction. Directed tests
// cover the encoding extremes and the malformed cases. Random tests mix
// well-formed text with overlong, surrogate, out-of-range, cut-off and stray
// bytes, plus raw noise. Both sides idle at random, and one test holds the
// result side off long enough to stall the byte input.
// ============================================================================
module utf8_stream_decoder_core_tb import utf8sd_pkg::*; ();

   localparam int unsigned STALL_LIMIT  = 2000;
   localparam int unsigned HOLD_CYCLES  = 300;
   localparam int unsigned TAIL_CYCLES  = 8;
   localparam int unsigned PRINT_LIMIT  = 50;
   localparam logic [7:0]  LEAD_TWO_MIN = 8'hC2;
   localparam logic [7:0]  LEAD_FOUR_MAX = 8'hF4;
   localparam result_type  REPLACED_RESULT = '{REPLACEMENT_CP, 1'b1, 1'b0, 1'b0};

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'd0;
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   seq_len_type         open_len;
   logic [2:0]          open_taken;
   logic [CP_WIDTH-1:0] open_value;
   logic                open_legal;

   result_type  decoded_q[$];
   logic [7:0]  text_bytes[$];
   int unsigned error_count  = 0;
   int unsigned bytes_sent   = 0;
   int unsigned hold_left    = 0;
   int unsigned stall_left   = 0;
   int unsigned quiet_cycles = 0;
   bit          hold_req     = 1'b0;
   bit          gaps_on      = 1'b1;

   utf8_stream_decoder_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int unsigned pick_gap();
      int unsigned roll;
      if (!gaps_on) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic void clear_open();
      open_len   = LEN_NONE;
      open_taken = 3'd0;
      open_value = '0;
      open_legal = 1'b1;
   endfunction

   // decoded results of one accepted byte, appended to decoded_q
   function automatic void decode_byte(input logic [7:0] b, input logic fin);
      result_type          outs[2];
      int                  n;
      logic                as_lead;
      logic [CP_WIDTH-1:0] low_bound;
      n = 0;
      as_lead = 1'b1;
      if (open_len != LEN_NONE) begin
         if (b[7:6] == 2'b10) begin
            as_lead = 1'b0;
            open_value = {open_value[CP_WIDTH-7:0], b[5:0]};
            open_taken = open_taken + 3'd1;
            if (open_taken >= open_len) begin
               low_bound = (open_len == LEN_TWO) ? MIN_TWO :
                           (open_len == LEN_THREE) ? MIN_THREE : MIN_FOUR;
               if (!open_legal || open_value < low_bound || open_value > CP_MAX ||
                   (open_value >= SURROGATE_LO && open_value <= SURROGATE_HI))
                  outs[n] = REPLACED_RESULT;
               else
                  outs[n] = '{open_value, 1'b0, 1'b0, 1'b0};
               n++;
               clear_open();
            end
         end else begin
            // cut sequence, byte is then taken as a new lead
            outs[n] = REPLACED_RESULT;
            n++;
            clear_open();
         end
      end
      if (as_lead) begin
         if (b[7] == 1'b0) begin
            outs[n] = '{{13'd0, b}, 1'b0, 1'b0, 1'b0};
            n++;
         end else if (b[7:5] == 3'b110) begin
            open_len   = LEN_TWO;
            open_value = {16'd0, b[4:0]};
            open_legal = (b >= LEAD_TWO_MIN);
            open_taken = 3'd1;
         end else if (b[7:4] == 4'b1110) begin
            open_len   = LEN_THREE;
            open_value = {17'd0, b[3:0]};
            open_legal = 1'b1;
            open_taken = 3'd1;
         end else if (b[7:3] == 5'b11110) begin
            open_len   = LEN_FOUR;
            open_value = {18'd0, b[2:0]};
            open_legal = (b <= LEAD_FOUR_MAX);
            open_taken = 3'd1;
         end else begin
            outs[n] = REPLACED_RESULT;
            n++;
         end
      end
      if (fin) begin
         if (open_len != LEN_NONE) begin
            outs[n] = REPLACED_RESULT;
            n++;
         end
         clear_open();
      end
      if (n > 0) begin
         outs[n-1].run_last = 1'b1;
         outs[n-1].text_end = fin;
      end
      for (int i = 0; i < n; i++) decoded_q.insert(decoded_q.size(), outs[i]);
   endfunction

   task automatic report_mismatch(input string what, input logic [23:0] got,
                                  input logic [23:0] want);
      if (error_count < PRINT_LIMIT)
         $display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $time);
      error_count++;
   endtask

   always @(posedge clock) begin : check_results
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (decoded_q.size() == 0) begin
            report_mismatch("unexpected transaction", rsp_tdata, 24'd0);
         end else begin
            want = decoded_q.pop_front();
            if (rsp_tdata[23:21] != 3'd0)
               report_mismatch("tdata padding", rsp_tdata, 24'd0);
            if (rsp_tdata[20:0] != want.char_value)
               report_mismatch("char_value", 24'(rsp_tdata[20:0]), 24'(want.char_value));
            if (rsp_tuser[0] != want.replaced)
               report_mismatch("replaced", 24'(rsp_tuser[0]), 24'(want.replaced));
            if (rsp_tuser[1] != want.run_last)
               report_mismatch("run_last", 24'(rsp_tuser[1]), 24'(want.run_last));
            if (rsp_tlast != want.text_end)
               report_mismatch("text_end", 24'(rsp_tlast), 24'(want.text_end));
         end
      end
   end

   // result side: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (hold_req) begin
         hold_left = HOLD_CYCLES;
         hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         stall_left = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
         rsp_tready <= (stall_left == 0);
         if (stall_left > 0) stall_left--;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", quiet_cycles);
         $display("** utf8_stream_decoder_core: FAILED **");
         $finish;
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic fin);
      int unsigned gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= fin;
      do @(posedge clock); while (!req_tready);
      decode_byte(b, fin);
      bytes_sent++;
   endtask

   task automatic send_text(input bit fin);
      int unsigned last;
      last = text_bytes.size() - 1;
      foreach (text_bytes[i]) send_byte(text_bytes[i], fin && (i == last));
      text_bytes.delete();
   endtask

   function automatic void add_byte(input logic [7:0] b);
      text_bytes.insert(text_bytes.size(), b);
   endfunction

   // utf-8 form of cp in len bytes, overlong or out of range when asked
   function automatic void put_utf8(input logic [CP_WIDTH-1:0] cp, input int unsigned len);
      case (len)
         1: add_byte({1'b0, cp[6:0]});
         2: begin
            add_byte({3'b110, cp[10:6]});
            add_byte({2'b10, cp[5:0]});
         end
         3: begin
            add_byte({4'b1110, cp[15:12]});
            add_byte({2'b10, cp[11:6]});
            add_byte({2'b10, cp[5:0]});
         end
         default: begin
            add_byte({5'b11110, cp[20:18]});
            add_byte({2'b10, cp[17:12]});
            add_byte({2'b10, cp[11:6]});
            add_byte({2'b10, cp[5:0]});
         end
      endcase
   endfunction

   task automatic wait_for_idle();
      req_tvalid <= 1'b0;
      while (decoded_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   task automatic test_well_formed();
      text_bytes = '{8'h00, 8'h7F};
      send_text(1'b0);
      text_bytes = '{8'hC2, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
      send_text(1'b1);
      wait_for_idle();
   endtask

   task automatic test_special_cases();
      // stray byte, illegal two-byte lead, overlong, surrogate, above range
      text_bytes = '{8'hFF, 8'hC0, 8'hAF, 8'hE0, 8'h80, 8'h80, 8'hED, 8'hA0, 8'h80,
                     8'hF4, 8'h90, 8'h80, 8'h80};
      send_text(1'b0);
      // cut by a new lead, then cut by the end of text
      text_bytes = '{8'hC3, 8'h41, 8'hE2};
      send_text(1'b1);
      wait_for_idle();
   endtask

   task automatic test_backpressure();
      gaps_on  = 1'b0;
      hold_req = 1'b1;
      for (int i = 0; i < 20; i++) put_utf8(CP_WIDTH'($urandom_range('h80, 'h7FF)), 2);
      send_text(1'b1);
      wait_for_idle();
      gaps_on = 1'b1;
   endtask

   task automatic test_random_text(input int unsigned budget);
      int unsigned         first, kind, len;
      logic [CP_WIDTH-1:0] cp;
      bit                  fin;
      first = bytes_sent;
      gaps_on = 1'b1;
      while (bytes_sent - first < budget) begin
         if ($urandom_range(0, 40) == 0) gaps_on = !gaps_on;
         kind = $urandom_range(0, 19);
         fin  = ($urandom_range(0, 9) == 0);
         if (kind < 14) begin
            len = $urandom_range(1, 4);
            case (len)
               1: cp = CP_WIDTH'($urandom_range(0, 'h7F));
               2: cp = CP_WIDTH'($urandom_range('h80, 'h7FF));
               3: begin
                  cp = CP_WIDTH'($urandom_range('h800, 'hFFFF));
                  if (cp >= SURROGATE_LO && cp <= SURROGATE_HI) cp = cp ^ 21'h2000;
               end
               default: cp = CP_WIDTH'($urandom_range('h10000, 'h10FFFF));
            endcase
            put_utf8(cp, len);
         end else begin
            case (kind)
               14: begin
                  len = $urandom_range(2, 4);
                  cp  = CP_WIDTH'((len == 2) ? $urandom_range(0, 'h7F) :
                                  (len == 3) ? $urandom_range(0, 'h7FF) :
                                               $urandom_range(0, 'hFFFF));
                  put_utf8(cp, len);
               end
               15: put_utf8(CP_WIDTH'($urandom_range('hD800, 'hDFFF)), 3);
               16: put_utf8(CP_WIDTH'($urandom_range('h110000, 'h1FFFFF)), 4);
               17: begin
                  len = $urandom_range(2, 4);
                  put_utf8(CP_WIDTH'($urandom_range(0, 'h1FFFFF)), len);
                  repeat ($urandom_range(1, len - 1)) void'(text_bytes.pop_back());
               end
               18: add_byte(8'($urandom_range(0, 1) ? $urandom_range('h80, 'hBF) :
                                                      $urandom_range('hF8, 'hFF)));
               default: add_byte(8'($urandom_range(0, 255)));
            endcase
         end
         send_text(fin);
      end
      gaps_on = 1'b1;
      wait_for_idle();
   endtask

   task automatic test_random_noise(input int unsigned budget);
      gaps_on = 1'b1;
      for (int unsigned i = 0; i < budget; i++) begin
         if ($urandom_range(0, 60) == 0) gaps_on = !gaps_on;
         send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
      end
      gaps_on = 1'b1;
      wait_for_idle();
   endtask

   initial begin
      clear_open();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_well_formed();
      test_special_cases();
      test_backpressure();
      test_random_text(1330);
      test_random_noise(450);
      if (error_count == 0)
         $display("** utf8_stream_decoder_core: PASSED **");
      else
         $display("** utf8_stream_decoder_core: FAILED **");
      $finish;
   end

endmodule
